[src/local_symbol_table_macros.svh]
// Assertion macros used by the local symbol table checker.
`ifndef LOCAL_SYMBOL_TABLE_MACROS_SVH
`define LOCAL_SYMBOL_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("local_symbol_table: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("local_symbol_table: next-cycle check failed");

`endif

[src/lst_pkg.sv]
// Shared types and constants of the local symbol table.
package lst_pkg;

    localparam int DEF_MAX_ENTRIES = 32;
    localparam int DEF_MAX_NAME    = 8;
    localparam int DEF_TYPE_BITS   = 8;

    localparam int OPCODE_W    = 3;
    localparam int NAME_PORT_W = 56;
    localparam int SLOT_OUT_W  = 5;
    localparam int COUNT_OUT_W = 6;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR    = 3'd0,
        OP_FIND     = 3'd1,
        OP_DECLARE  = 3'd2,
        OP_TRUNCATE = 3'd3,
        OP_QUERY    = 3'd4,
        OP_SET_TYPE = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_QUERY
    } state_t;

endpackage

[src/local_symbol_table.sv]
// Top level of the local symbol table: sequencer, entry memories and result registers.

// A word is taken when start is high and busy is low; its result appears on the
// result ports for exactly one cycle with done high, and the receiver cannot stall
// it. Clear, truncate, set type and the unused opcodes answer in the cycle after
// acceptance; query answers from the query state. Find and declare walk the
// visible entries through one shared name comparator fed by the name memory's
// single read port, one entry per cycle: a miss answers once every visible entry
// is compared, or from the scan state when the table is empty or the length is
// zero; a hit answers when the entry at its slot is compared, and a declare with
// an over-long name answers in the cycle after acceptance. Busy falls in the cycle
// that done is shown, so the next word may be taken then. No clearing pass follows
// reset: entries are read only below the count, and each one was written first.
module local_symbol_table
    import lst_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int MAX_NAME    = DEF_MAX_NAME,
    parameter int TYPE_BITS   = DEF_TYPE_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [OPCODE_W-1:0]    opcode,
    input  logic [NAME_PORT_W-1:0] name_bytes,
    input  logic [7:0]             name_length,
    input  logic                   let_flag_in,
    input  logic [7:0]             type_in,
    input  logic [7:0]             slot_in,
    input  logic [7:0]             keep_count,
    input  logic                   cfg_we,
    input  logic [7:0]             cfg_wdata,
    output logic                   done,
    output logic                   ok,
    output logic [SLOT_OUT_W-1:0]  slot_out,
    output logic                   let_flag_out,
    output logic [7:0]             type_out,
    output logic [COUNT_OUT_W-1:0] entry_count
);

    localparam int LIM    = MAX_NAME - 1;
    localparam int NAME_W = 8 * LIM;
    localparam int LEN_W  = $clog2(MAX_NAME);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    // Entry memories.
    logic [NAME_W-1:0]    name_mem [MAX_ENTRIES];
    logic                 let_mem  [MAX_ENTRIES];
    logic [TYPE_BITS-1:0] type_mem [MAX_ENTRIES];

    // Control registers.
    state_t               state_reg, state_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     issue_reg, issue_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [7:0]           unknown_reg;

    // Payload registers.
    op_t                  op_reg, op_next;
    logic [NAME_W-1:0]    name_reg, name_next;
    logic [LEN_W-1:0]     clen_reg, clen_next;
    logic                 len_zero_reg, len_zero_next;
    logic                 let_reg, let_next;
    logic [TYPE_BITS-1:0] type_reg, type_next;
    logic                 qhit_reg, qhit_next;
    logic [IDX_W-1:0]     pend_idx_reg, pend_idx_next;
    logic [NAME_W-1:0]    name_rd_reg;
    logic                 let_rd_reg;
    logic [TYPE_BITS-1:0] type_rd_reg;
    logic                 ok_reg, ok_next;
    logic [SLOT_OUT_W-1:0] slot_reg, slot_next;
    logic                 let_out_reg, let_out_next;
    logic [7:0]           type_out_reg, type_out_next;

    logic                 accept;
    logic                 slot_in_range;
    logic                 decl_we;
    logic                 set_we;
    logic                 scan_hit;
    logic                 scan_miss;
    logic [LEN_W-1:0]     clen_in;
    logic [NAME_W-1:0]    name_masked;

    // Stored byte i must equal the given byte below the length, and the byte
    // right after a short name must be zero.
    function automatic logic names_match(input logic [NAME_W-1:0] stored,
                                         input logic [NAME_W-1:0] given,
                                         input logic [LEN_W-1:0]  clen);
        logic m;
        m = 1'b1;
        for (int i = 0; i < LIM; i++) begin
            if (LEN_W'(i) < clen) begin
                if (stored[8*i +: 8] != given[8*i +: 8]) begin
                    m = 1'b0;
                end
            end
            else if (LEN_W'(i) == clen) begin
                if (stored[8*i +: 8] != 8'h00) begin
                    m = 1'b0;
                end
            end
        end
        return m;
    endfunction

    assign accept        = start && !busy;
    assign busy          = (state_reg != ST_IDLE);
    assign slot_in_range = (slot_in < 8'(count_reg));
    assign set_we        = accept && (opcode == OP_SET_TYPE) && slot_in_range;

    assign clen_in = (name_length >= 8'(LIM)) ? LEN_W'(LIM) : name_length[LEN_W-1:0];

    always_comb
    begin
        for (int i = 0; i < LIM; i++) begin
            name_masked[8*i +: 8] = (LEN_W'(i) < clen_in) ? name_bytes[8*i +: 8] : 8'h00;
        end
    end

    assign scan_hit  = pend_valid_reg && !len_zero_reg &&
                       names_match(name_rd_reg, name_reg, clen_reg);
    assign scan_miss = len_zero_reg || (!pend_valid_reg && (issue_reg >= count_reg));

    always_comb
    begin
        state_next      = state_reg;
        done_next       = 1'b0;
        count_next      = count_reg;
        issue_next      = issue_reg;
        pend_valid_next = pend_valid_reg;
        op_next         = op_reg;
        name_next       = name_reg;
        clen_next       = clen_reg;
        len_zero_next   = len_zero_reg;
        let_next        = let_reg;
        type_next       = type_reg;
        qhit_next       = qhit_reg;
        pend_idx_next   = pend_idx_reg;
        ok_next         = ok_reg;
        slot_next       = slot_reg;
        let_out_next    = let_out_reg;
        type_out_next   = type_out_reg;
        decl_we         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    op_next         = op_t'(opcode);
                    name_next       = name_masked;
                    clen_next       = clen_in;
                    len_zero_next   = (name_length == 8'd0);
                    let_next        = let_flag_in;
                    type_next       = type_in[TYPE_BITS-1:0];
                    qhit_next       = slot_in_range;
                    issue_next      = '0;
                    pend_valid_next = 1'b0;
                    ok_next         = 1'b1;
                    slot_next       = '0;
                    let_out_next    = 1'b0;
                    type_out_next   = 8'h00;
                    case (opcode)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            done_next  = 1'b1;
                        end
                        OP_FIND:
                        begin
                            state_next = ST_SCAN;
                        end
                        OP_DECLARE:
                        begin
                            if (name_length >= 8'(MAX_NAME)) begin
                                ok_next   = 1'b0;
                                done_next = 1'b1;
                            end
                            else begin
                                state_next = ST_SCAN;
                            end
                        end
                        OP_TRUNCATE:
                        begin
                            if (keep_count < 8'(count_reg)) begin
                                count_next = CNT_W'(keep_count);
                            end
                            done_next = 1'b1;
                        end
                        OP_QUERY:
                        begin
                            state_next = ST_QUERY;
                        end
                        default:
                        begin
                            // Set type writes the memory at this edge; unused
                            // opcodes only answer.
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_hit || scan_miss) begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    if (op_reg == OP_FIND) begin
                        ok_next   = scan_hit;
                        slot_next = scan_hit ? SLOT_OUT_W'(pend_idx_reg) : '0;
                    end
                    else if (scan_hit || (count_reg == CNT_W'(MAX_ENTRIES))) begin
                        ok_next   = 1'b0;
                        slot_next = '0;
                    end
                    else begin
                        decl_we    = 1'b1;
                        ok_next    = 1'b1;
                        slot_next  = SLOT_OUT_W'(count_reg);
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                else if (issue_reg < count_reg) begin
                    // Read one entry while the previous one is compared.
                    issue_next      = issue_reg + CNT_W'(1);
                    pend_valid_next = 1'b1;
                    pend_idx_next   = issue_reg[IDX_W-1:0];
                end
                else begin
                    pend_valid_next = 1'b0;
                end
            end
            ST_QUERY:
            begin
                state_next    = ST_IDLE;
                done_next     = 1'b1;
                ok_next       = 1'b1;
                slot_next     = '0;
                let_out_next  = qhit_reg ? let_rd_reg : 1'b0;
                type_out_next = qhit_reg ? 8'(type_rd_reg) : unknown_reg;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= ST_IDLE;
            done_reg       <= 1'b0;
            count_reg      <= '0;
            issue_reg      <= '0;
            pend_valid_reg <= 1'b0;
            unknown_reg    <= 8'h00;
        end
        else begin
            state_reg      <= state_next;
            done_reg       <= done_next;
            count_reg      <= count_next;
            issue_reg      <= issue_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_we) begin
                unknown_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        name_reg     <= name_next;
        clen_reg     <= clen_next;
        len_zero_reg <= len_zero_next;
        let_reg      <= let_next;
        type_reg     <= type_next;
        qhit_reg     <= qhit_next;
        pend_idx_reg <= pend_idx_next;
        ok_reg       <= ok_next;
        slot_reg     <= slot_next;
        let_out_reg  <= let_out_next;
        type_out_reg <= type_out_next;
    end

    // Name memory: written by declare, read by the scan.
    always_ff @(posedge clk)
    begin
        if (decl_we) begin
            name_mem[count_reg[IDX_W-1:0]] <= name_reg;
        end
        name_rd_reg <= name_mem[issue_reg[IDX_W-1:0]];
    end

    // Flag and type memories: read at the requested slot as the word is taken.
    always_ff @(posedge clk)
    begin
        if (decl_we) begin
            let_mem[count_reg[IDX_W-1:0]] <= let_reg;
        end
        let_rd_reg <= let_mem[slot_in[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (decl_we) begin
            type_mem[count_reg[IDX_W-1:0]] <= type_reg;
        end
        else if (set_we) begin
            type_mem[slot_in[IDX_W-1:0]] <= type_in[TYPE_BITS-1:0];
        end
        type_rd_reg <= type_mem[slot_in[IDX_W-1:0]];
    end

    assign done         = done_reg;
    assign ok           = ok_reg;
    assign slot_out     = slot_reg;
    assign let_flag_out = let_out_reg;
    assign type_out     = type_out_reg;
    assign entry_count  = COUNT_OUT_W'(count_reg);

endmodule

[src/lst_checker.sv]
// Port-level checker for the local symbol table and its bind statement.
`include "local_symbol_table_macros.svh"

module lst_checker
    import lst_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   start,
    input logic                   busy,
    input logic [OPCODE_W-1:0]    opcode,
    input logic                   done,
    input logic                   ok,
    input logic [SLOT_OUT_W-1:0]  slot_out,
    input logic [COUNT_OUT_W-1:0] entry_count
);

    // A result is shown only once the sequencer is free again.
    `LST_ASSERT_NOW(a_done_not_busy, clk, rst_n, done, !busy)

    // Every accepted word either keeps the block busy or answers at once.
    `LST_ASSERT_NEXT(a_accept_progress, clk, rst_n, start && !busy, busy || done)

    // Clear answers in the next cycle with an empty table.
    `LST_ASSERT_NEXT(a_clear_empties, clk, rst_n, start && !busy && (opcode == OP_CLEAR),
                     done && (entry_count == '0))

    // A failed find or declare reports slot zero.
    `LST_ASSERT_NOW(a_fail_slot_zero, clk, rst_n, done && !ok, slot_out == '0)

    // The count never passes the table depth when a result is shown.
    `LST_ASSERT_NOW(a_count_bound, clk, rst_n, done, entry_count <= COUNT_OUT_W'(MAX_ENTRIES))

endmodule

bind local_symbol_table lst_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_lst_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .done        (done),
    .ok          (ok),
    .slot_out    (slot_out),
    .entry_count (entry_count)
);

[sim/local_symbol_table_tb.sv]
// Self-checking testbench for the local symbol table: directed and random words against a predictor.
module local_symbol_table_tb;
    import lst_pkg::*;

    localparam int NAME_LIM      = DEF_MAX_NAME - 1;
    localparam int POOL_SIZE     = 64;
    localparam int PHASES        = 6;
    localparam int PHASE_WORDS   = 310;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = DEF_MAX_ENTRIES + 8;

    // Opcodes six and seven are not in the package enum; the block treats them as no-ops.
    localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

    typedef struct {
        logic [OPCODE_W-1:0]    opcode;
        logic [NAME_PORT_W-1:0] name;
        logic [7:0]             len;
        logic                   let_flag;
        logic [7:0]             type_code;
        logic [7:0]             slot;
        logic [7:0]             keep;
    } table_word_t;

    typedef struct packed {
        logic                   ok;
        logic [SLOT_OUT_W-1:0]  slot;
        logic                   let_flag;
        logic [7:0]             type_code;
        logic [COUNT_OUT_W-1:0] count;
    } table_reply_t;

    class symbol_scoreboard;
        logic [NAME_PORT_W-1:0] names [DEF_MAX_ENTRIES];
        logic                   lets [DEF_MAX_ENTRIES];
        logic [7:0]             kinds [DEF_MAX_ENTRIES];
        int                     visible;
        logic [7:0]             unknown_code;
        table_reply_t           expected [$];
        int                     errors;

        function new();
            visible = 0;
            unknown_code = '0;
            errors = 0;
        endfunction

        // Only the first NAME_LIM bytes count; a shorter name must be followed by a zero byte.
        function bit name_matches(logic [NAME_PORT_W-1:0] stored, logic [NAME_PORT_W-1:0] given,
                                  int len);
            int n;
            n = (len < NAME_LIM) ? len : NAME_LIM;
            for (int i = 0; i < n; i++)
                if (stored[8*i +: 8] != given[8*i +: 8])
                    return 1'b0;
            if (n < NAME_LIM && stored[8*n +: 8] != 8'h00)
                return 1'b0;
            return 1'b1;
        endfunction

        function int lowest_match(logic [NAME_PORT_W-1:0] name, int len);
            if (len == 0)
                return -1;
            for (int i = 0; i < visible; i++)
                if (name_matches(names[i], name, len))
                    return i;
            return -1;
        endfunction

        function void note_word(table_word_t w);
            table_reply_t r;
            int hit;
            logic [63:0] keep_mask;
            r = '0;
            r.ok = 1'b1;
            case (w.opcode)
                OP_CLEAR: visible = 0;
                OP_FIND: begin
                    hit = lowest_match(w.name, int'(w.len));
                    if (hit >= 0)
                        r.slot = hit[SLOT_OUT_W-1:0];
                    else
                        r.ok = 1'b0;
                end
                OP_DECLARE: begin
                    if (int'(w.len) >= DEF_MAX_NAME || lowest_match(w.name, int'(w.len)) >= 0 ||
                        visible >= DEF_MAX_ENTRIES) begin
                        r.ok = 1'b0;
                    end else begin
                        keep_mask = (64'd1 << (8 * w.len)) - 64'd1;
                        names[visible] = w.name & keep_mask[NAME_PORT_W-1:0];
                        lets[visible] = w.let_flag;
                        kinds[visible] = w.type_code;
                        r.slot = visible[SLOT_OUT_W-1:0];
                        visible++;
                    end
                end
                OP_TRUNCATE: begin
                    if (int'(w.keep) < visible)
                        visible = int'(w.keep);
                end
                OP_QUERY: begin
                    if (int'(w.slot) < visible) begin
                        r.let_flag = lets[w.slot[SLOT_OUT_W-1:0]];
                        r.type_code = kinds[w.slot[SLOT_OUT_W-1:0]];
                    end else begin
                        r.type_code = unknown_code;
                    end
                end
                OP_SET_TYPE: begin
                    if (int'(w.slot) < visible)
                        kinds[w.slot[SLOT_OUT_W-1:0]] = w.type_code;
                end
                default: ;
            endcase
            r.count = visible[COUNT_OUT_W-1:0];
            expected.push_back(r);
        endfunction

        function void check_field(string label, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, label, want, got);
            end
        endfunction

        function void check_reply(table_reply_t got);
            table_reply_t want;
            if (expected.size() == 0) begin
                errors++;
                $display("%0t: result with no word pending: expected none, actual %0h",
                         $time, got);
                return;
            end
            want = expected.pop_front();
            check_field("ok", 32'(want.ok), 32'(got.ok));
            check_field("slot_out", 32'(want.slot), 32'(got.slot));
            check_field("let_flag_out", 32'(want.let_flag), 32'(got.let_flag));
            check_field("type_out", 32'(want.type_code), 32'(got.type_code));
            check_field("entry_count", 32'(want.count), 32'(got.count));
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [OPCODE_W-1:0]    opcode = OP_CLEAR;
    logic [NAME_PORT_W-1:0] name_bytes = '0;
    logic [7:0]             name_length = '0;
    logic                   let_flag_in = 1'b0;
    logic [7:0]             type_in = '0;
    logic [7:0]             slot_in = '0;
    logic [7:0]             keep_count = '0;
    logic                   cfg_we = 1'b0;
    logic [7:0]             cfg_wdata = '0;
    logic                   done;
    logic                   ok;
    logic [SLOT_OUT_W-1:0]  slot_out;
    logic                   let_flag_out;
    logic [7:0]             type_out;
    logic [COUNT_OUT_W-1:0] entry_count;

    symbol_scoreboard       sb;
    int unsigned            cycle_count = 0;
    logic [NAME_PORT_W-1:0] pool_name [POOL_SIZE];
    logic [7:0]             pool_len [POOL_SIZE];
    logic [7:0]             letters [4] = '{8'h00, 8'h61, 8'h62, 8'hFF};
    int                     declare_weight [PHASES] = '{34, 60, 34, 60, 34, 45};
    bit                     idle_on [PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

    local_symbol_table dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .name_bytes   (name_bytes),
        .name_length  (name_length),
        .let_flag_in  (let_flag_in),
        .type_in      (type_in),
        .slot_in      (slot_in),
        .keep_count   (keep_count),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .done         (done),
        .ok           (ok),
        .slot_out     (slot_out),
        .let_flag_out (let_flag_out),
        .type_out     (type_out),
        .entry_count  (entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_reply(table_reply_t'{ok, slot_out, let_flag_out, type_out, entry_count});
    end

    function automatic table_word_t word_of(logic [OPCODE_W-1:0] op, logic [NAME_PORT_W-1:0] name,
                                            logic [7:0] len, logic let_flag,
                                            logic [7:0] type_code, logic [7:0] slot,
                                            logic [7:0] keep);
        table_word_t w;
        w.opcode = op;
        w.name = name;
        w.len = len;
        w.let_flag = let_flag;
        w.type_code = type_code;
        w.slot = slot;
        w.keep = keep;
        return w;
    endfunction

    // Puts a pool name under the random bytes; the bytes above its length stay as garbage.
    function automatic table_word_t with_pool_name(table_word_t w);
        int k;
        logic [63:0] low_mask;
        k = $urandom_range(0, POOL_SIZE - 1);
        low_mask = (64'd1 << (8 * pool_len[k])) - 64'd1;
        w.name = (w.name & ~low_mask[NAME_PORT_W-1:0]) | pool_name[k];
        w.len = pool_len[k];
        return w;
    endfunction

    function automatic table_word_t random_word(int dw);
        table_word_t w;
        logic [63:0] raw;
        int pick;
        int cnt;
        int r;
        cnt = sb.visible;
        raw = {$urandom, $urandom};
        w = word_of(OP_QUERY, raw[NAME_PORT_W-1:0], 8'($urandom_range(0, NAME_LIM)),
                    1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        pick = $urandom_range(0, dw + 61);
        r = $urandom_range(0, 19);
        if (pick < dw) begin
            w.opcode = OP_DECLARE;
            w = with_pool_name(w);
            if (r == 0)
                w.len = 0;
            else if (r == 1)
                w.len = 8'($urandom_range(DEF_MAX_NAME, 255));
        end else if (pick < dw + 30) begin
            w.opcode = OP_FIND;
            if (r != 4)
                w = with_pool_name(w);
            if (r == 0)
                w.len = 0;
            else if (r < 4)
                w.len = 8'($urandom_range(DEF_MAX_NAME, 255));
        end else if (pick < dw + 52) begin
            w.opcode = (pick < dw + 42) ? OP_QUERY : OP_SET_TYPE;
            if ($urandom_range(0, 5) != 0)
                w.slot = 8'($urandom_range(0, cnt + 1));
        end else if (pick < dw + 58) begin
            w.opcode = OP_TRUNCATE;
            if ($urandom_range(0, 3) != 0)
                w.keep = 8'((cnt > 3) ? cnt - $urandom_range(0, 3) : $urandom_range(0, cnt));
        end else if (pick < dw + 60) begin
            w.opcode = OP_CLEAR;
        end else begin
            w.opcode = ($urandom_range(0, 1) != 0) ? OP_SPARE_LO : OP_SPARE_HI;
        end
        return w;
    endfunction

    // Holds the word on the ports until the block takes it.
    task automatic send_word(table_word_t w);
        opcode <= w.opcode;
        name_bytes <= w.name;
        name_length <= w.len;
        let_flag_in <= w.let_flag;
        type_in <= w.type_code;
        slot_in <= w.slot;
        keep_count <= w.keep;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        sb.note_word(w);
    endtask

    task automatic idle_for(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (sb.expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_unknown_code(logic [7:0] code);
        cfg_we <= 1'b1;
        cfg_wdata <= code;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.unknown_code = code;
    endtask

    initial
    begin
        logic [7:0] code;
        sb = new();
        // Few letters, zero bytes included, so prefixes and duplicates come up often.
        for (int k = 0; k < POOL_SIZE; k++) begin
            pool_len[k] = 8'(($urandom_range(0, 2) == 0) ? NAME_LIM
                                                         : $urandom_range(1, NAME_LIM));
            pool_name[k] = '0;
            for (int b = 0; b < pool_len[k]; b++)
                pool_name[k][8*b +: 8] = letters[2'($urandom_range(0, 3))];
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(word_of(OP_QUERY, '0, 0, 0, 0, 0, 0));
        send_word(word_of(OP_FIND, '0, 0, 0, 0, 0, 0));
        send_word(word_of(OP_DECLARE, 56'h123456789ABCDE, 0, 1, 8'h3C, 0, 0));
        send_word(word_of(OP_FIND, 56'h123456789ABCDE, 0, 0, 0, 0, 0));
        send_word(word_of(OP_DECLARE, 56'hDEADBEEF006261, 2, 1, 8'hFF, 0, 0));
        send_word(word_of(OP_DECLARE, 56'h00000000006261, 2, 0, 8'h11, 0, 0));
        send_word(word_of(OP_DECLARE, 56'h00000000006263, 8'(DEF_MAX_NAME), 0, 0, 0, 0));
        send_word(word_of(OP_DECLARE, 56'h00000000006263, 8'hFF, 0, 0, 0, 0));
        send_word(word_of(OP_DECLARE, {NAME_PORT_W{1'b1}}, 8'(NAME_LIM), 0, 8'h00, 0, 0));
        send_word(word_of(OP_FIND, {NAME_PORT_W{1'b1}}, 8'd200, 0, 0, 0, 0));
        send_word(word_of(OP_FIND, 56'h00000000000061, 1, 0, 0, 0, 0));
        send_word(word_of(OP_FIND, 56'hFFFFFFFFFF6261, 2, 0, 0, 0, 0));
        send_word(word_of(OP_QUERY, '0, 0, 0, 0, 1, 0));
        send_word(word_of(OP_SET_TYPE, '0, 0, 0, 8'h00, 1, 0));
        send_word(word_of(OP_QUERY, '0, 0, 0, 0, 1, 0));
        send_word(word_of(OP_SET_TYPE, '0, 0, 0, 8'h77, 8'hFF, 0));
        send_word(word_of(OP_QUERY, '0, 0, 0, 0, 8'hFF, 0));
        send_word(word_of(OP_TRUNCATE, '0, 0, 0, 0, 0, 8'hFF));
        send_word(word_of(OP_TRUNCATE, '0, 0, 0, 0, 0, 2));
        send_word(word_of(OP_SPARE_LO, '1, 8'hFF, 1, 8'hFF, 8'hFF, 8'hFF));
        send_word(word_of(OP_SPARE_HI, '0, 0, 0, 0, 0, 0));
        send_word(word_of(OP_CLEAR, '0, 0, 0, 0, 0, 0));
        send_word(word_of(OP_QUERY, '0, 0, 0, 0, 0, 0));

        for (int p = 0; p < PHASES; p++) begin
            // The register may only change while no word is in flight.
            drain_results();
            case (p)
                0: code = 8'hFF;
                1: code = 8'h00;
                3: code = 8'h80;
                5: code = 8'h01;
                default: code = 8'($urandom_range(0, 255));
            endcase
            write_unknown_code(code);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                send_word(random_word(declare_weight[p]));
                if (idle_on[p] && $urandom_range(0, 5) == 0)
                    idle_for($urandom_range(1, 13));
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/lst_pkg.sv
src/local_symbol_table.sv
src/lst_checker.sv
sim/local_symbol_table_tb.sv
